@@ sv/mma_pkg.sv @@
package mma_pkg;

    // Block configuration
    localparam int CHANNELS   = 4;
    localparam int MAX_WINDOW = 16;

    // Field widths
    localparam int CH_W     = 2;
    localparam int SAMPLE_W = 16;
    localparam int WIN_W    = 5;
    localparam int SUM_W    = 21;

    // Derived sizes
    localparam int NUM_REGS = 4;
    localparam int DEPTH    = MAX_WINDOW * CHANNELS;
    localparam int ROW_W    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int CIDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W    = $clog2(SUM_W + 1);
    localparam int PADDR_W  = $clog2(NUM_REGS) + 2;
    localparam int PDATA_W  = 32;

    // Register indexes
    localparam logic [PADDR_W-3:0] REG_WIN_CH0 = 2'd0;
    localparam logic [PADDR_W-3:0] REG_WIN_CH1 = 2'd1;
    localparam logic [PADDR_W-3:0] REG_WIN_CH2 = 2'd2;
    localparam logic [PADDR_W-3:0] REG_WIN_CH3 = 2'd3;

    localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(1);

    // Saturation limits of the average
    localparam logic [SAMPLE_W-1:0] AVG_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic [SAMPLE_W-1:0] AVG_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SUM,
        S_DIV,
        S_OUT
    } state_t;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [WIN_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] quotient;
    } div_resp_t;

endpackage

@@ sv/mma_in_if.sv @@
interface mma_in_if import mma_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [CH_W-1:0]     channel;
    logic [SAMPLE_W-1:0] sample;
    logic                row_end;
    logic                restart;

    modport source (output valid, output channel, output sample, output row_end,
                    output restart, input ready);
    modport sink   (input valid, input channel, input sample, input row_end,
                    input restart, output ready);

endinterface

@@ sv/mma_out_if.sv @@
interface mma_out_if import mma_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [CH_W-1:0]     channel_out;
    logic [SAMPLE_W-1:0] average;
    logic                row_end_out;

    modport source (output valid, output channel_out, output average,
                    output row_end_out, input ready);
    modport sink   (input valid, input channel_out, input average,
                    input row_end_out, output ready);

endinterface

@@ sv/multichannel_moving_average.sv @@
// Moving average over the last W rows, per channel, of signed 16-bit samples.
// An item with a window above one goes from acceptance through the history
// read, the sum update, the bit-serial divider that produces one quotient bit
// per cycle, a step that takes the quotient and applies the sign, and the load
// of the output register; a window of 0 or 1, or a channel out of range, skips
// the divider. The input is ready again the cycle after the load, so a new
// item is taken only once the last one is through; a result still waiting in
// the output register holds the next one back at the load step. Window lengths
// are written through the APB port at byte address 4*channel; the user must
// write them only while idle, as the block itself does not enforce it.
// History entries carry valid bits, so reset and restart need no clearing pass.
module multichannel_moving_average import mma_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    mma_in_if.sink             in_chan,
    mma_out_if.source          out_chan
);

    state_t state_reg;
    state_t state_next;

    logic [WIN_W-1:0]    win_reg [NUM_REGS];
    logic [SUM_W-1:0]    sum_reg [CHANNELS];
    logic [ROW_W-1:0]    ptr_reg;

    logic [SAMPLE_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]    vld_reg;
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic                rd_vld_reg;

    logic [CH_W-1:0]     ch_reg;
    logic [SAMPLE_W-1:0] smp_reg;
    logic                row_end_reg;
    logic [WIN_W-1:0]    w_reg;
    logic                pass_reg;
    logic                ch_ok_reg;
    logic                neg_reg;
    logic [SAMPLE_W-1:0] result_reg;

    logic                out_valid_reg;
    logic [CH_W-1:0]     out_ch_reg;
    logic [SAMPLE_W-1:0] out_avg_reg;
    logic                out_row_end_reg;

    logic                in_fire;
    logic                load_out;
    logic                cfg_wr;
    logic [PADDR_W-3:0]  cfg_idx;

    logic [WIN_W-1:0]    win_sel;
    logic [WIN_W-1:0]    win_sat;
    logic                ch_ok;
    logic [ROW_W+1:0]    row_tmp;
    logic [ROW_W-1:0]    old_row;
    logic [ADDR_W-1:0]   rd_addr;
    logic [ADDR_W-1:0]   wr_addr;
    logic [CIDX_W-1:0]   sidx;
    logic [SUM_W-1:0]    old_ext;
    logic [SUM_W-1:0]    new_sum;
    logic [SUM_W-1:0]    new_mag;
    logic [SAMPLE_W-1:0] div_result;

    div_req_t  div_req;
    div_resp_t div_resp;

    mma_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .resp  (div_resp)
    );

    // Configuration port
    assign pready  = 1'b1;
    assign cfg_idx = paddr[PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;
    assign prdata  = PDATA_W'(win_reg[cfg_idx]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                win_reg[i] <= WIN_RESET;
            end
        end
        else if (cfg_wr)
        begin
            win_reg[cfg_idx] <= pwdata[WIN_W-1:0];
        end
    end

    // Handshakes
    assign in_fire              = in_chan.valid && in_chan.ready;
    assign in_chan.ready        = (state_reg == S_IDLE);
    assign out_chan.valid       = out_valid_reg;
    assign out_chan.channel_out = out_ch_reg;
    assign out_chan.average     = out_avg_reg;
    assign out_chan.row_end_out = out_row_end_reg;

    // Window lookup and saturation at acceptance
    always_comb
    begin
        win_sel = win_reg[in_chan.channel];
        if (int'(win_sel) > MAX_WINDOW)
        begin
            win_sat = WIN_W'(MAX_WINDOW);
        end
        else
        begin
            win_sat = win_sel;
        end
        ch_ok = (int'(in_chan.channel) < CHANNELS);
    end

    // Addresses of the leaving sample and of the new one
    always_comb
    begin
        row_tmp = (ROW_W+2)'(ptr_reg) + (ROW_W+2)'(MAX_WINDOW) - (ROW_W+2)'(w_reg);
        if (row_tmp >= (ROW_W+2)'(MAX_WINDOW))
        begin
            row_tmp = row_tmp - (ROW_W+2)'(MAX_WINDOW);
        end
        old_row = row_tmp[ROW_W-1:0];
        rd_addr = ADDR_W'(old_row) * ADDR_W'(CHANNELS) + ADDR_W'(ch_reg);
        wr_addr = ADDR_W'(ptr_reg) * ADDR_W'(CHANNELS) + ADDR_W'(ch_reg);
        sidx    = CIDX_W'(ch_reg);
    end

    // Running sum update and its magnitude for the divider
    always_comb
    begin
        old_ext = rd_vld_reg ? SUM_W'($signed(rd_data_reg)) : '0;
        new_sum = sum_reg[sidx] - old_ext + SUM_W'($signed(smp_reg));
        new_mag = new_sum[SUM_W-1] ? (~new_sum + 1'b1) : new_sum;
    end

    assign div_req.start    = (state_reg == S_SUM) && !pass_reg;
    assign div_req.dividend = new_mag;
    assign div_req.divisor  = w_reg;

    // Apply the sign and saturate the quotient
    always_comb
    begin
        if (neg_reg)
        begin
            if (div_resp.quotient > SUM_W'(AVG_MIN))
            begin
                div_result = AVG_MIN;
            end
            else
            begin
                div_result = SAMPLE_W'(~div_resp.quotient + 1'b1);
            end
        end
        else
        begin
            if (div_resp.quotient > SUM_W'(AVG_MAX))
            begin
                div_result = AVG_MAX;
            end
            else
            begin
                div_result = div_resp.quotient[SAMPLE_W-1:0];
            end
        end
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and output load
    always_comb
    begin
        state_next = state_reg;
        load_out   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_chan.valid)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_SUM;
            end
            S_SUM:
            begin
                state_next = pass_reg ? S_OUT : S_DIV;
            end
            S_DIV:
            begin
                if (div_resp.done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_chan.ready)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state: sums, ring pointer, valid bits, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                sum_reg[i] <= '0;
            end
            ptr_reg       <= '0;
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // Clear history and sums on restart
            if (in_fire && in_chan.restart)
            begin
                for (int i = 0; i < CHANNELS; i++)
                begin
                    sum_reg[i] <= '0;
                end
                ptr_reg <= '0;
                vld_reg <= '0;
            end
            // Update sum, mark the stored entry and advance on row end
            if (state_reg == S_SUM)
            begin
                if (!pass_reg)
                begin
                    sum_reg[sidx] <= new_sum;
                end
                if (ch_ok_reg)
                begin
                    vld_reg[wr_addr] <= 1'b1;
                end
                if (row_end_reg)
                begin
                    if (ptr_reg == ROW_W'(MAX_WINDOW - 1))
                    begin
                        ptr_reg <= '0;
                    end
                    else
                    begin
                        ptr_reg <= ptr_reg + 1'b1;
                    end
                end
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_chan.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // History memory: read the leaving sample, write the new one
    always_ff @(posedge clk)
    begin
        if (state_reg == S_READ)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_vld_reg  <= vld_reg[rd_addr];
        end
        if ((state_reg == S_SUM) && ch_ok_reg)
        begin
            mem[wr_addr] <= smp_reg;
        end
    end

    // Item payload and result
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            ch_reg      <= in_chan.channel;
            smp_reg     <= in_chan.sample;
            row_end_reg <= in_chan.row_end;
            w_reg       <= win_sat;
            ch_ok_reg   <= ch_ok;
            pass_reg    <= !ch_ok || (win_sat <= WIN_W'(1));
        end
        if (state_reg == S_SUM)
        begin
            neg_reg    <= new_sum[SUM_W-1];
            result_reg <= smp_reg;
        end
        if ((state_reg == S_DIV) && div_resp.done)
        begin
            result_reg <= div_result;
        end
        if (load_out)
        begin
            out_ch_reg      <= ch_reg;
            out_avg_reg     <= result_reg;
            out_row_end_reg <= row_end_reg;
        end
    end

endmodule

@@ sv/mma_div.sv @@
// Restoring divider, one quotient bit per cycle, unsigned operands.
module mma_div import mma_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  div_req_t  req,
    output div_resp_t resp
);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [SUM_W-1:0] dq_reg;
    logic [WIN_W-1:0] rem_reg;
    logic [WIN_W-1:0] dvs_reg;

    logic [WIN_W:0]   trial;
    logic             qbit;
    logic [WIN_W-1:0] rem_next;

    // Trial subtraction of the divisor from the shifted remainder
    always_comb
    begin
        trial = {rem_reg, dq_reg[SUM_W-1]};
        qbit  = (trial >= {1'b0, dvs_reg});
        if (qbit)
        begin
            rem_next = WIN_W'(trial - {1'b0, dvs_reg});
        end
        else
        begin
            rem_next = trial[WIN_W-1:0];
        end
    end

    // Control: count the steps and flag the last one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(SUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift quotient bits in as dividend bits leave
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dq_reg  <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            dq_reg  <= {dq_reg[SUM_W-2:0], qbit};
            rem_reg <= rem_next;
        end
    end

    assign resp.done     = done_reg;
    assign resp.quotient = dq_reg;

endmodule

@@ dv/tb_multichannel_moving_average.sv @@
module tb_multichannel_moving_average import mma_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  RESET_CYCLES = 8;
    localparam int  DRAIN_CYCLES = 40;
    localparam int  LONG_HOLD    = 400;
    localparam int  PHASES       = 6;
    localparam int  PHASE_ITEMS  = 184;
    localparam real RUN_LIMIT_NS = 1000000.0;

    typedef struct packed {
        logic [CH_W-1:0]            channel;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       row_end;
        logic                       restart;
    } sample_item_t;

    typedef struct packed {
        logic [CH_W-1:0]     channel;
        logic [SAMPLE_W-1:0] average;
        logic                row_end;
    } avg_result_t;

    localparam logic [PADDR_W-3:0] WIN_REG [CHANNELS] =
        '{REG_WIN_CH0, REG_WIN_CH1, REG_WIN_CH2, REG_WIN_CH3};

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    mma_in_if  in_if ();
    mma_out_if out_if ();

    multichannel_moving_average dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .in_chan  (in_if),
        .out_chan (out_if)
    );

    // Shadow of the block state
    logic signed [SAMPLE_W-1:0] sample_hist [DEPTH];
    logic signed [SUM_W-1:0]    run_sum [CHANNELS];
    logic [ROW_W-1:0]           row_ptr;
    logic [WIN_W-1:0]           win_len [CHANNELS];

    avg_result_t pending_averages [$];
    int          fail_count;
    int          burst_left;
    bit          no_gaps;
    bit          hold_request;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("*** FAILED ***");
        $finish;
    end

    task automatic report_mismatch(string what, longint exp_val, longint got_val);
        $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, exp_val, got_val);
        fail_count++;
    endtask

    function automatic void clear_history();
        for (int i = 0; i < DEPTH; i++)
            sample_hist[i] = '0;
        for (int c = 0; c < CHANNELS; c++)
            run_sum[c] = '0;
        row_ptr = '0;
    endfunction

    // Advance the shadow state by one item and return its average
    function automatic avg_result_t predict_average(sample_item_t it);
        avg_result_t                r;
        int                         w;
        int                         old_row;
        int                         cur;
        int                         q;
        logic signed [SAMPLE_W-1:0] old_smp;
        if (it.restart)
            clear_history();
        r.channel = it.channel;
        r.row_end = it.row_end;
        r.average = it.sample;
        w = int'(win_len[it.channel]);
        if (w > MAX_WINDOW)
            w = MAX_WINDOW;
        cur = int'(row_ptr) * CHANNELS + int'(it.channel);
        if (w > 1)
        begin
            old_row = (int'(row_ptr) + MAX_WINDOW - w) % MAX_WINDOW;
            old_smp = sample_hist[old_row * CHANNELS + int'(it.channel)];
            run_sum[it.channel] = run_sum[it.channel] - SUM_W'(old_smp)
                                  + SUM_W'(it.sample);
            q = int'(run_sum[it.channel]);
            q = q / w;
            if (q > 32767)
                q = 32767;
            if (q < -32768)
                q = -32768;
            r.average = q[SAMPLE_W-1:0];
        end
        sample_hist[cur] = it.sample;
        if (it.row_end)
            row_ptr = row_ptr + 1'b1;
        return r;
    endfunction

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        avg_result_t exp_r;
        if (rst_n && out_if.valid && out_if.ready)
        begin
            if (pending_averages.size() == 0)
                report_mismatch("unexpected result, channel", -1,
                                longint'(out_if.channel_out));
            else
            begin
                exp_r = pending_averages.pop_front();
                if (out_if.channel_out !== exp_r.channel)
                    report_mismatch("channel_out", longint'(exp_r.channel),
                                    longint'(out_if.channel_out));
                if (out_if.average !== exp_r.average)
                    report_mismatch("average", longint'($signed(exp_r.average)),
                                    longint'($signed(out_if.average)));
                if (out_if.row_end_out !== exp_r.row_end)
                    report_mismatch("row_end_out", longint'(exp_r.row_end),
                                    longint'(out_if.row_end_out));
            end
        end
    end

    // Receiver: random stall segments, and a long hold on request
    initial
    begin
        int seg_left;
        int stall_pct;
        seg_left  = 0;
        stall_pct = 0;
        out_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_if.ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
            end
            else
            begin
                if (seg_left == 0)
                begin
                    seg_left = $urandom_range(80, 10);
                    case ($urandom_range(4, 0))
                        0, 1:    stall_pct = 0;
                        2:       stall_pct = 25;
                        3:       stall_pct = 50;
                        default: stall_pct = 80;
                    endcase
                end
                seg_left--;
                out_if.ready <= ($urandom_range(99, 0) >= stall_pct);
            end
        end
    end

    // Offer one item, with burst pacing, and hold it until accepted
    task automatic send_item(logic [CH_W-1:0] ch, logic [SAMPLE_W-1:0] smp,
                             logic re, logic rs);
        sample_item_t it;
        int           gap;
        if (!no_gaps && burst_left == 0)
        begin
            burst_left = $urandom_range(12, 1);
            gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
            if (gap > 0)
            begin
                @(negedge clk);
                in_if.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        if (burst_left > 0)
            burst_left--;
        it.channel = ch;
        it.sample  = smp;
        it.row_end = re;
        it.restart = rs;
        @(negedge clk);
        in_if.valid   <= 1'b1;
        in_if.channel <= ch;
        in_if.sample  <= smp;
        in_if.row_end <= re;
        in_if.restart <= rs;
        @(posedge clk);
        while (!in_if.ready)
            @(posedge clk);
        pending_averages.push_back(predict_average(it));
    endtask

    // Drop valid and wait until every expected result has come back
    task automatic wait_drained();
        @(negedge clk);
        in_if.valid <= 1'b0;
        burst_left = 0;
        while (pending_averages.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write one window register, then read it back
    task automatic write_window(int ch, logic [WIN_W-1:0] len);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {WIN_REG[ch], 2'b00};
        pwdata  <= PDATA_W'(len);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        win_len[ch] = len;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[WIN_W-1:0] !== len)
            report_mismatch("window readback", longint'(len),
                            longint'(prdata[WIN_W-1:0]));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(7, 0))
            0:       return AVG_MAX;
            1:       return AVG_MIN;
            2:       return SAMPLE_W'($urandom_range(8, 0)) - 16'd4;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic [WIN_W-1:0] pick_window();
        case ($urandom_range(5, 0))
            0:       return 5'd0;
            1:       return 5'd1;
            2:       return 5'd16;
            3:       return WIN_W'($urandom_range(31, 17));
            default: return WIN_W'($urandom_range(15, 2));
        endcase
    endfunction

    // Windows at reset pass samples straight through
    task automatic test_reset_passthrough();
        send_item(2'd0, AVG_MAX, 1'b0, 1'b0);
        send_item(2'd1, AVG_MIN, 1'b0, 1'b0);
        send_item(2'd2, 16'hFFFF, 1'b0, 1'b0);
        send_item(2'd3, 16'h0000, 1'b1, 1'b0);
        send_item(2'd3, 16'h0001, 1'b1, 1'b0);
    endtask

    // Large sums with a shrunk window saturate the average
    task automatic test_average_saturation();
        wait_drained();
        write_window(0, 5'd16);
        write_window(1, 5'd16);
        for (int r = 0; r < 3; r++)
        begin
            send_item(2'd0, AVG_MAX, 1'b0, r == 0);
            send_item(2'd1, AVG_MIN, 1'b1, 1'b0);
        end
        wait_drained();
        write_window(0, 5'd2);
        write_window(1, 5'd2);
        send_item(2'd0, AVG_MAX, 1'b0, 1'b0);
        send_item(2'd1, AVG_MIN, 1'b1, 1'b0);
    endtask

    // Window 0, oversized window, truncation, repeated channel and restart
    task automatic test_restart_and_repeats();
        wait_drained();
        write_window(0, 5'd0);
        write_window(1, 5'd31);
        write_window(2, 5'd1);
        write_window(3, 5'd3);
        send_item(2'd3, 16'hFFF9, 1'b0, 1'b0);
        send_item(2'd3, 16'h0005, 1'b0, 1'b0);
        send_item(2'd0, 16'hFFFF, 1'b0, 1'b0);
        send_item(2'd1, 16'h0001, 1'b0, 1'b0);
        send_item(2'd2, 16'h1234, 1'b1, 1'b0);
        send_item(2'd3, 16'hFFFE, 1'b1, 1'b1);
    endtask

    // Random rows over several window settings
    task automatic test_random_rows();
        int sent;
        bit rs;
        for (int p = 0; p < PHASES; p++)
        begin
            wait_drained();
            for (int c = 0; c < CHANNELS; c++)
            begin
                case (p)
                    1:       write_window(c, 5'd16);
                    2:       write_window(c, (c == 0) ? 5'd0 : (c == 1) ? 5'd1 :
                                             (c == 2) ? 5'd31 : 5'd2);
                    default: write_window(c, pick_window());
                endcase
            end
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                if ($urandom_range(99, 0) < 85)
                begin
                    rs = ($urandom_range(49, 0) == 0);
                    for (int c = 0; c < CHANNELS; c++)
                        send_item(CH_W'(c), pick_sample(), c == CHANNELS - 1, rs && c == 0);
                    sent += CHANNELS;
                end
                else
                begin
                    send_item(CH_W'($urandom_range(3, 0)), pick_sample(),
                              1'($urandom_range(1, 0)), $urandom_range(19, 0) == 0);
                    sent++;
                end
            end
        end
    endtask

    // Long receiver hold while the sender keeps offering
    task automatic test_backpressure();
        no_gaps = 1'b1;
        hold_request = 1'b1;
        for (int r = 0; r < 8; r++)
            for (int c = 0; c < CHANNELS; c++)
                send_item(CH_W'(c), pick_sample(), c == CHANNELS - 1, 1'b0);
        no_gaps = 1'b0;
    endtask

    initial
    begin
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_if.valid   = 1'b0;
        in_if.channel = '0;
        in_if.sample  = '0;
        in_if.row_end = 1'b0;
        in_if.restart = 1'b0;
        fail_count    = 0;
        burst_left    = 0;
        no_gaps       = 1'b0;
        hold_request  = 1'b0;
        clear_history();
        for (int c = 0; c < CHANNELS; c++)
            win_len[c] = WIN_RESET;
        rst_n = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        test_reset_passthrough();
        test_average_saturation();
        test_restart_and_repeats();
        test_random_rows();
        test_backpressure();
        wait_drained();

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
